@@ src/sfsf_pkg.sv @@
// Package with the shared types, widths and coil table of the stepper full-step follower.
`timescale 1ns / 1ps

package sfsf_pkg;

	// Default fixed-point format of the followed position.
	localparam int FRAC_BITS_DEF   = 16;
	localparam int COUNT_WIDTH_DEF = 32;

	// Fixed field widths of the streams and registers.
	localparam int TARGET_W    = 32;
	localparam int OUT_COUNT_W = 32;
	localparam int PHASE_W     = 2;
	localparam int DUTY_W      = 17;
	localparam int STEP_REG_W  = 32;
	localparam int CFG_DATA_W  = 32;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 104;

	// The step limit register holds Q16.16 counts.
	localparam int STEP_REG_FRAC = 16;

	localparam logic [STEP_REG_W-1:0] STEP_RESET = 32'd65536;
	localparam logic [DUTY_W-1:0]     DUTY_FULL  = 17'd65536;

	typedef enum logic [0:0] {
		REG_MAX_STEP = 1'b0,
		REG_MAX_DUTY = 1'b1
	} cfg_reg_t;

	// Energized coils per phase; bit 0 is A+, bit 1 is B+, bit 2 is A-, bit 3 is B-.
	typedef logic [3:0] coil_row_t;

	localparam coil_row_t COIL_ROWS [4] = '{4'b0011, 4'b0110, 4'b1100, 4'b1001};

	function automatic coil_row_t coil_row(input logic [PHASE_W-1:0] ph);
		return COIL_ROWS[ph];
	endfunction

endpackage

@@ src/stepper_full_step_follower_unit.sv @@
// Top level of the two-phase full-step stepper follower.
`timescale 1ns / 1ps

// Usage overview.
// The slave stream (s_tvalid, s_tready, s_tdata) carries one control tick per
// transaction; s_tdata holds the signed target position in whole steps.
// The master stream (m_tvalid, m_tready, m_tdata) returns exactly one result
// transaction per tick: the followed whole-step count, the full-step phase
// and the four coil duties.
// Each tick is captured in an input register; from there the position
// update, the truncation to whole steps, the phase move and the coil lookup
// are computed and written into the output register, which drives m_tvalid.
// Throughput is one tick per cycle while the receiver keeps m_tready high.
// The only loop is the position and phase state, which closes through one
// subtract, one clamp and one add on the position word.
// A stalled receiver holds the result in the output register. The input
// register takes one more tick if it is empty or its tick moves on; while
// it holds a tick that cannot move on, s_tready is low, following m_tready.
// The asynchronous reset clears the position, the phase and both stream
// valids, and loads the step limit with one step per tick and full duty.
// The user must write the configuration port (cfg_we, cfg_index, cfg_data)
// only while idle; the block itself does not enforce it.
module stepper_full_step_follower_unit #(
	parameter int FRAC_BITS   = sfsf_pkg::FRAC_BITS_DEF,
	parameter int COUNT_WIDTH = sfsf_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  sfsf_pkg::cfg_reg_t                cfg_index,
	input  logic [sfsf_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Slave stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata: [31:0] target_count
	input  logic [sfsf_pkg::IN_TDATA_W-1:0]   s_tdata,
	// Master stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: [31:0] current_count, [33:32] phase, [50:34] duty_a_pos,
	// [67:51] duty_b_pos, [84:68] duty_a_neg, [101:85] duty_b_neg, [103:102] zero
	output logic [sfsf_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	import sfsf_pkg::*;

	// Position word and the widths of the step limit and the difference.
	localparam int PW     = COUNT_WIDTH + FRAC_BITS;
	localparam int UP     = (FRAC_BITS >= STEP_REG_FRAC) ? FRAC_BITS - STEP_REG_FRAC : 0;
	localparam int DN     = (FRAC_BITS < STEP_REG_FRAC) ? STEP_REG_FRAC - FRAC_BITS : 0;
	localparam int LIM_W  = STEP_REG_W + UP;
	localparam int DW     = ((PW + 1) > (LIM_W + 1)) ? PW + 1 : LIM_W + 1;

	// Saturation bounds of the target in whole steps.
	localparam logic signed [63:0] T_HI = (64'sd1 <<< (COUNT_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] T_LO = -T_HI - 64'sd1;

	localparam logic [LIM_W-1:0] LIM_RESET = (LIM_W'(STEP_RESET) << UP) >> DN;

	// Configuration registers.
	logic [LIM_W-1:0]  lim_q;
	logic [DUTY_W-1:0] duty_q;
	logic [DUTY_W-1:0] cfg_duty;

	// Follower state.
	logic signed [PW-1:0]          pos_q;
	logic signed [COUNT_WIDTH-1:0] count_q;
	logic [PHASE_W-1:0]            phase_q;

	// Input stage.
	logic                   valid_s1;
	logic signed [PW-1:0]   target_fx_s1;

	// Output stage.
	logic                     valid_s2;
	logic [OUT_COUNT_W-1:0]   count_s2;
	logic [PHASE_W-1:0]       phase_s2;
	logic [DUTY_W-1:0]        duty_a_pos_s2;
	logic [DUTY_W-1:0]        duty_b_pos_s2;
	logic [DUTY_W-1:0]        duty_a_neg_s2;
	logic [DUTY_W-1:0]        duty_b_neg_s2;

	// Handshake.
	logic in_xfer;
	logic out_free;
	logic load;

	// Combinational update.
	logic signed [TARGET_W-1:0]    tgt_raw;
	logic signed [63:0]            tgt_wide;
	logic signed [63:0]            tgt_sat;
	logic signed [COUNT_WIDTH-1:0] tgt_cw;
	logic signed [PW-1:0]          tgt_fx;
	logic signed [DW-1:0]          diff;
	logic signed [DW-1:0]          lim_s;
	logic signed [DW-1:0]          step;
	logic signed [DW-1:0]          pos_sum;
	logic signed [PW-1:0]          pos_next;
	logic signed [COUNT_WIDTH-1:0] floor_cnt;
	logic                          round_up;
	logic signed [COUNT_WIDTH-1:0] count_next;
	logic                          count_moved;
	logic [PHASE_W-1:0]            phase_next;
	coil_row_t                     row_next;

	// The output register is free when empty or being emptied this cycle.
	assign out_free = !valid_s2 || m_tready;
	assign load     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign in_xfer  = s_tvalid && s_tready;

	// Target saturated to the count range and placed on the fixed-point grid.
	assign tgt_raw  = s_tdata[TARGET_W-1:0];
	assign tgt_wide = 64'(tgt_raw);
	assign tgt_sat  = (tgt_wide > T_HI) ? T_HI : ((tgt_wide < T_LO) ? T_LO : tgt_wide);
	assign tgt_cw   = tgt_sat[COUNT_WIDTH-1:0];
	assign tgt_fx   = {tgt_cw, {FRAC_BITS{1'b0}}};

	// Move toward the target by no more than the limit.
	assign diff    = DW'(target_fx_s1) - DW'(pos_q);
	assign lim_s   = signed'(DW'(lim_q));
	assign step    = (diff > lim_s) ? lim_s : ((diff < -lim_s) ? -lim_s : diff);
	assign pos_sum = DW'(pos_q) + step;
	assign pos_next = pos_sum[PW-1:0];

	// Truncation toward zero: the arithmetic shift floors, so a negative
	// position with a nonzero fraction rounds up by one.
	assign floor_cnt  = pos_next[PW-1:FRAC_BITS];
	assign round_up   = pos_next[PW-1] && (|pos_next[FRAC_BITS-1:0]);
	assign count_next = floor_cnt + (round_up ? COUNT_WIDTH'(1) : '0);

	// The phase moves one place per tick whenever the whole count changes,
	// however many steps the count jumped.
	assign count_moved = (count_next != count_q);
	always_comb begin
		phase_next = phase_q;
		if (count_moved) begin
			if (step[DW-1]) begin
				phase_next = phase_q - PHASE_W'(1);
			end else begin
				phase_next = phase_q + PHASE_W'(1);
			end
		end
	end

	assign row_next = coil_row(phase_next);

	// Duty writes above full scale saturate.
	assign cfg_duty = (cfg_data[DUTY_W-1:0] > DUTY_FULL) ? DUTY_FULL : cfg_data[DUTY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q  <= LIM_RESET;
			duty_q <= DUTY_FULL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_STEP: lim_q  <= (LIM_W'(cfg_data) << UP) >> DN;
				REG_MAX_DUTY: duty_q <= cfg_duty;
			endcase
		end
	end

	// Control state of both stages and the follower state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pos_q    <= '0;
			count_q  <= '0;
			phase_q  <= '0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				valid_s2 <= 1'b1;
				pos_q    <= pos_next;
				count_q  <= count_next;
				phase_q  <= phase_next;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			target_fx_s1 <= tgt_fx;
		end
		if (load) begin
			count_s2      <= OUT_COUNT_W'(count_next);
			phase_s2      <= phase_next;
			duty_a_pos_s2 <= row_next[0] ? duty_q : '0;
			duty_b_pos_s2 <= row_next[1] ? duty_q : '0;
			duty_a_neg_s2 <= row_next[2] ? duty_q : '0;
			duty_b_neg_s2 <= row_next[3] ? duty_q : '0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, duty_b_neg_s2, duty_a_neg_s2, duty_b_pos_s2, duty_a_pos_s2,
		phase_s2, count_s2};

	// The phase only moves when a tick is written into the output register.
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(phase_q))
		else $error("phase changed without a tick");

	// A change of the whole count always moves the phase by one place.
	a_phase_moves: assert property (@(posedge clk) disable iff (!arst_n)
		load && count_moved |=> (phase_q == $past(phase_q) + PHASE_W'(1)) ||
			(phase_q == $past(phase_q) - PHASE_W'(1)))
		else $error("whole count changed but phase did not step");

	// Opposite ends of one coil are never driven together.
	a_coil_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((duty_a_pos_s2 == '0) || (duty_a_neg_s2 == '0)) &&
			((duty_b_pos_s2 == '0) || (duty_b_neg_s2 == '0)))
		else $error("both ends of a coil energized");

	// Input is refused only while a tick waits in the input register.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2)
		else $error("input refused with room available");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench of the stepper full-step follower: stream driver, predictor and monitor.
`timescale 1ns / 1ps

// The block follows a commanded whole-step target with a fixed-point position
// that may move at most max_step_per_tick per tick. The testbench predicts
// every result transaction at the moment the matching tick is accepted and
// compares the monitored results, field by field, in order.
//
// The stimulus is built in phases. Between phases the sender stops, every
// predicted result is waited for, and only then are the registers rewritten,
// so the block is always idle when its configuration changes.
module tb_top;
	import sfsf_pkg::*;

	// Result fields as they are packed on m_tdata, lowest field last.
	typedef struct packed {
		logic [1:0]         pad;
		logic [16:0]        b_neg;
		logic [16:0]        a_neg;
		logic [16:0]        b_pos;
		logic [16:0]        a_pos;
		logic [1:0]         phase;
		logic signed [31:0] count;
	} step_result_t;

	localparam int FRAC = 16;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	cfg_reg_t               cfg_index = REG_MAX_STEP;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	stepper_full_step_follower_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Targets waiting to be sent, and the results predicted for accepted ticks.
	logic [31:0]  target_q[$];
	step_result_t expected_q[$];

	// Predictor state: position in Q32.16, phase, and the register copies.
	longint   follow_pos = 0;
	bit [1:0] follow_phase = '0;
	bit [31:0] step_limit = STEP_RESET;
	bit [16:0] duty_level = DUTY_FULL;

	int mismatches = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int src_gap = 0;
	int sink_gap = 0;

	// Whole steps of a Q32.16 position, truncated toward zero.
	function automatic longint whole_steps(input longint p);
		if (p >= 0)
			return p >>> FRAC;
		return -((-p) >>> FRAC);
	endfunction

	// Advances the follower by one tick and returns the result it must emit.
	function automatic step_result_t follow_tick(input logic signed [31:0] target);
		longint     target_fx, delta, lim, prev_cnt, now_cnt;
		bit [3:0]   coils;
		step_result_t r;
		target_fx = longint'(target) * (64'sd1 << FRAC);
		lim = step_limit;
		delta = target_fx - follow_pos;
		if (delta > lim)
			delta = lim;
		if (delta < -lim)
			delta = -lim;
		prev_cnt = whole_steps(follow_pos);
		follow_pos += delta;
		now_cnt = whole_steps(follow_pos);
		// A change of the whole count moves the phase by one place only,
		// however many steps were crossed in this tick.
		if (now_cnt != prev_cnt)
			follow_phase = (delta >= 0) ? follow_phase + 2'd1 : follow_phase - 2'd1;
		// Energized coils as {B-, A-, B+, A+} for the two-phase-on sequence.
		case (follow_phase)
			2'd0: coils = 4'b0011;
			2'd1: coils = 4'b0110;
			2'd2: coils = 4'b1100;
			default: coils = 4'b1001;
		endcase
		r = '0;
		r.count = now_cnt[31:0];
		r.phase = follow_phase;
		r.a_pos = coils[0] ? duty_level : '0;
		r.b_pos = coils[1] ? duty_level : '0;
		r.a_neg = coils[2] ? duty_level : '0;
		r.b_neg = coils[3] ? duty_level : '0;
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Sender: presents queued targets, holds a transaction until it is taken,
	// and inserts idle bursts between transactions.
	always @(posedge clk) begin : tick_driver
		logic present;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_q.push_back(follow_tick(s_tdata));
			present = s_tvalid && !s_tready;
			if (!present) begin
				if (src_gap > 0)
					src_gap--;
				else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
					src_gap = $urandom_range(0, 17);
				else if (target_q.size() != 0) begin
					present = 1'b1;
					s_tdata <= target_q.pop_front();
				end
			end
			s_tvalid <= present;
		end
	end

	// Receiver: checks each result transaction against the oldest prediction
	// and stalls in random bursts.
	always @(posedge clk) begin : result_monitor
		step_result_t got, want;
		logic take;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = step_result_t'(m_tdata);
				if (expected_q.size() == 0) begin
					$error("result transaction with no tick waiting, count %0d", got.count);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					check_field("current_count", want.count, got.count);
					check_field("phase", want.phase, got.phase);
					check_field("duty_a_pos", want.a_pos, got.a_pos);
					check_field("duty_b_pos", want.b_pos, got.b_pos);
					check_field("duty_a_neg", want.a_neg, got.a_neg);
					check_field("duty_b_neg", want.b_neg, got.b_neg);
					check_field("tdata padding", want.pad, got.pad);
				end
			end
			take = 1'b1;
			if (sink_gap > 0) begin
				sink_gap--;
				take = 1'b0;
			end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
				sink_gap = $urandom_range(0, 17);
				take = 1'b0;
			end
			m_tready <= take;
		end
	end

	// Returns at a falling edge once nothing is queued, in flight or predicted.
	task automatic wait_drained();
		@(negedge clk);
		while (target_q.size() != 0 || s_tvalid || expected_q.size() != 0)
			@(negedge clk);
	endtask

	// Register write; the predictor copy follows the same masking and clamp.
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_MAX_STEP)
			step_limit = value;
		else
			duty_level = (value[16:0] > DUTY_FULL) ? DUTY_FULL : value[16:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_limit();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return $urandom_range(1, 65535);
			2: return STEP_RESET;
			3: return $urandom_range(65536, 32'h0010_0000);
			4: return $urandom;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] pick_duty();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'd65536;
			2: return $urandom_range(0, 65536);
			3: return $urandom_range(65537, 32'h1_FFFF);
			default: return $urandom;
		endcase
	endfunction

	initial begin : stimulus
		longint      walk;
		int          pick;
		logic [31:0] first_targets [8];
		logic [31:0] edge_targets [4];
		int          idle_levels [3];
		first_targets = '{32'd3, 32'd3, 32'd0, 32'hFFFF_FFFE, 32'h8000_0000,
			32'h7FFF_FFFF, 32'd0, 32'd0};
		edge_targets = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF};
		idle_levels = '{0, 3, 12};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: one step per tick, full duty. Field extremes and
		// direction reversals.
		src_idle_pct = 10;
		sink_idle_pct = 10;
		foreach (first_targets[i])
			target_q.push_back(first_targets[i]);
		wait_drained();

		// Zero limit: the position must hold and the phase stay put.
		write_reg(REG_MAX_STEP, 32'd0);
		write_reg(REG_MAX_DUTY, 32'd0);
		target_q.push_back(32'd100);
		target_q.push_back(-32'sd100);
		target_q.push_back(32'h7FFF_FFFF);
		wait_drained();

		// Largest limit: multi-step jumps, and a duty write above full that
		// has to saturate.
		write_reg(REG_MAX_STEP, 32'hFFFF_FFFF);
		write_reg(REG_MAX_DUTY, 32'hFFFF_FFFF);
		target_q.push_back(32'h7FFF_FFFF);
		target_q.push_back(32'h8000_0000);
		target_q.push_back(32'd0);
		target_q.push_back(32'd70000);
		target_q.push_back(-32'sd70000);
		target_q.push_back(32'd1);
		wait_drained();

		// Quarter-step limit: fractional positions below zero must truncate
		// toward zero before the count changes.
		write_reg(REG_MAX_STEP, 32'h0000_4000);
		write_reg(REG_MAX_DUTY, 32'h0001_0001);
		repeat (6)
			target_q.push_back(-32'sd3);
		target_q.push_back(32'd2);
		target_q.push_back(32'd2);
		wait_drained();

		// Random phases. Targets are mostly a short random walk so the count
		// keeps stepping both ways; the rest are jumps, extremes and noise.
		walk = 0;
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_MAX_STEP, pick_limit());
			write_reg(REG_MAX_DUTY, pick_duty());
			if (ph == 7) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end else begin
				src_idle_pct = idle_levels[$urandom_range(0, 2)];
				sink_idle_pct = idle_levels[$urandom_range(0, 2)];
			end
			repeat (116) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					walk += longint'($urandom_range(0, 16)) - 8;
					target_q.push_back(walk[31:0]);
				end else if (pick < 80) begin
					target_q.push_back($urandom);
				end else if (pick < 90) begin
					target_q.push_back(edge_targets[$urandom_range(0, 3)]);
				end else begin
					walk = longint'($urandom_range(0, 2000)) - 1000;
					target_q.push_back(walk[31:0]);
				end
			end
			wait_drained();
		end

		// Wait on so that any stray result is caught before the verdict.
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
